/* hw/rtl/pfe_pkg.sv */
package pfe_pkg;

  // Packet store limit: bytes beyond this many are dropped.
  localparam int MAX_PACKET_BYTES = 2048;
  // Byte position and packet length, wide enough to hold MAX_PACKET_BYTES itself.
  localparam int POS_W = $clog2(MAX_PACKET_BYTES) + 1;
  // Offsets that add a header offset, a word offset and a small constant.
  localparam int OFF_W = POS_W + 1;

  localparam int HDR_OFF_W = 11;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Header layout, in bytes from the start of the header concerned.
  localparam int IP_FRAG_HI_POS  = 6;
  localparam int IP_FRAG_LO_POS  = 7;
  localparam int IP_PROTO_POS    = 9;
  localparam int TCP_DOFF_POS    = 12;
  localparam int TCP_MIN_HDR     = 20;
  localparam int UDP_HDR_BYTES   = 8;
  localparam int WORD_BYTES      = 4;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    MODE_IP_HEADER = 3'd0,
    MODE_TCP_UDP   = 3'd1,
    MODE_TRANSPORT = 3'd2,
    MODE_PAYLOAD   = 3'd3,
    MODE_PROTOCOL  = 3'd4
  } pfe_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_MODE     = 3'd0,
    REG_MATCH_PROTOCOL = 3'd1,
    REG_WORD_OFFSET    = 3'd2,
    REG_SHIFT_AMOUNT   = 3'd3,
    REG_FIELD_MASK     = 3'd4,
    REG_FIELD_LENGTH   = 3'd5,
    REG_INCREMENTAL    = 3'd6
  } pfe_reg_e;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 first_byte;
    logic                 last_byte;
    logic                 has_net_header;
    logic [HDR_OFF_W-1:0] net_offset;
    logic [HDR_OFF_W-1:0] trans_offset;
    logic [WORD_W-1:0]    prior_aggregate;
  } pfe_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] aggregate;
    logic              rejected;
  } pfe_out_t;

  typedef struct packed {
    pfe_mode_e            field_mode;
    logic [7:0]           match_protocol;
    logic [HDR_OFF_W-1:0] word_offset;
    logic [4:0]           shift_amount;
    logic [WORD_W-1:0]    field_mask;
    logic [5:0]           field_length;
    logic                 incremental;
  } pfe_cfg_t;

  // What the byte scan knows about a packet once its last byte is in.
  typedef struct packed {
    logic [WORD_W-1:0]    word_ip;     // at net + word_offset
    logic [WORD_W-1:0]    word_l4;     // at trans + word_offset
    logic [WORD_W-1:0]    word_l4_4;   // at trans + 4 + word_offset
    logic [WORD_W-1:0]    word_l4_8;   // at trans + 8 + word_offset
    logic [WORD_W-1:0]    word_l4_dyn; // at trans + 4 * data offset + word_offset
    logic [7:0]           ip_protocol;
    logic                 frag_zero;
    logic [3:0]           tcp_data_words;
    logic [POS_W-1:0]     length;
    logic                 has_net;
    logic [HDR_OFF_W-1:0] net_offset;
    logic [HDR_OFF_W-1:0] trans_offset;
    logic [WORD_W-1:0]    prior;
  } pfe_summary_t;

endpackage

/* hw/rtl/pfe_scan.sv */
module pfe_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  pfe_pkg::pfe_in_t      item,
  input  pfe_pkg::pfe_cfg_t     cfg,
  output pfe_pkg::pfe_summary_t summary
);
  import pfe_pkg::*;

  logic [POS_W-1:0]     pos;
  logic                 has_net;
  logic [HDR_OFF_W-1:0] net_off;
  logic [HDR_OFF_W-1:0] trans_off;
  logic [WORD_W-1:0]    prior;
  logic [7:0]           hist [3];
  logic [7:0]           ip_protocol;
  logic [4:0]           frag_hi;
  logic [7:0]           frag_lo;
  logic [3:0]           tcp_words;
  logic                 dyn_armed;
  logic [OFF_W-1:0]     dyn_end;
  logic [WORD_W-1:0]    word_ip, word_l4, word_l4_4, word_l4_8, word_l4_dyn;

  logic                 start;
  logic [POS_W-1:0]     cur_pos;
  logic [OFF_W-1:0]     cur_pos_x;
  logic                 stored;
  logic                 eff_has_net;
  logic [HDR_OFF_W-1:0] eff_net, eff_trans;
  logic [WORD_W-1:0]    eff_prior;
  logic [OFF_W-1:0]     net_x, trans_x, wo_x;
  logic [WORD_W-1:0]    window;
  logic [7:0]           proto_next;
  logic [4:0]           frag_hi_next;
  logic [7:0]           frag_lo_next;
  logic [3:0]           tcp_words_next;
  logic                 dyn_armed_next;
  logic [OFF_W-1:0]     dyn_end_next;
  logic                 hit_doff;
  logic [POS_W-1:0]     pos_next;
  logic [WORD_W-1:0]    word_ip_next, word_l4_next, word_l4_4_next;
  logic [WORD_W-1:0]    word_l4_8_next, word_l4_dyn_next;

  // A packet starts on a marked first byte, or on any byte after a last byte.
  assign start     = item.first_byte || (pos == '0);
  assign cur_pos   = item.first_byte ? '0 : pos;
  assign cur_pos_x = OFF_W'(cur_pos);
  assign stored    = cur_pos < POS_W'(MAX_PACKET_BYTES);

  assign eff_has_net = item.first_byte ? item.has_net_header  : has_net;
  assign eff_net     = item.first_byte ? item.net_offset      : net_off;
  assign eff_trans   = item.first_byte ? item.trans_offset    : trans_off;
  assign eff_prior   = item.first_byte ? item.prior_aggregate : prior;

  assign net_x   = OFF_W'(eff_net);
  assign trans_x = OFF_W'(eff_trans);
  assign wo_x    = OFF_W'(cfg.word_offset);
  assign window  = {hist[2], hist[1], hist[0], item.data_byte};

  assign hit_doff = stored && (cur_pos_x == trans_x + OFF_W'(TCP_DOFF_POS));

  always_comb begin
    proto_next     = start ? '0 : ip_protocol;
    frag_hi_next   = start ? '0 : frag_hi;
    frag_lo_next   = start ? '0 : frag_lo;
    tcp_words_next = start ? '0 : tcp_words;
    dyn_armed_next = start ? 1'b0 : dyn_armed;
    dyn_end_next   = dyn_end;
    if (stored && (cur_pos_x == net_x + OFF_W'(IP_PROTO_POS))) begin
      proto_next = item.data_byte;
    end
    if (stored && (cur_pos_x == net_x + OFF_W'(IP_FRAG_HI_POS))) begin
      frag_hi_next = item.data_byte[4:0];
    end
    if (stored && (cur_pos_x == net_x + OFF_W'(IP_FRAG_LO_POS))) begin
      frag_lo_next = item.data_byte;
    end
    if (hit_doff) begin
      tcp_words_next = item.data_byte[7:4];
      dyn_armed_next = 1'b1;
      dyn_end_next   = trans_x + OFF_W'({item.data_byte[7:4], 2'b00}) + wo_x
                       + OFF_W'(WORD_BYTES - 1);
    end
  end

  // A word is taken when its last byte is the byte now arriving.
  always_comb begin
    word_ip_next     = word_ip;
    word_l4_next     = word_l4;
    word_l4_4_next   = word_l4_4;
    word_l4_8_next   = word_l4_8;
    word_l4_dyn_next = word_l4_dyn;
    if (stored) begin
      if (cur_pos_x == net_x + wo_x + OFF_W'(WORD_BYTES - 1)) begin
        word_ip_next = window;
      end
      if (cur_pos_x == trans_x + wo_x + OFF_W'(WORD_BYTES - 1)) begin
        word_l4_next = window;
      end
      if (cur_pos_x == trans_x + wo_x + OFF_W'(WORD_BYTES + WORD_BYTES - 1)) begin
        word_l4_4_next = window;
      end
      if (cur_pos_x == trans_x + wo_x + OFF_W'(UDP_HDR_BYTES + WORD_BYTES - 1)) begin
        word_l4_8_next = window;
      end
      if (!start && dyn_armed && (cur_pos_x == dyn_end)) begin
        word_l4_dyn_next = window;
      end
    end
  end

  assign pos_next = stored ? cur_pos + POS_W'(1) : cur_pos;

  always_comb begin
    summary.word_ip        = word_ip_next;
    summary.word_l4        = word_l4_next;
    summary.word_l4_4      = word_l4_4_next;
    summary.word_l4_8      = word_l4_8_next;
    summary.word_l4_dyn    = word_l4_dyn_next;
    summary.ip_protocol    = proto_next;
    summary.frag_zero      = (frag_hi_next == '0) && (frag_lo_next == '0);
    summary.tcp_data_words = tcp_words_next;
    summary.length         = pos_next;
    summary.has_net        = eff_has_net;
    summary.net_offset     = eff_net;
    summary.trans_offset   = eff_trans;
    summary.prior          = eff_prior;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      has_net     <= 1'b0;
      net_off     <= '0;
      trans_off   <= '0;
      prior       <= '0;
      ip_protocol <= '0;
      frag_hi     <= '0;
      frag_lo     <= '0;
      tcp_words   <= '0;
      dyn_armed   <= 1'b0;
    end else if (take) begin
      pos         <= item.last_byte ? '0 : pos_next;
      has_net     <= eff_has_net;
      net_off     <= eff_net;
      trans_off   <= eff_trans;
      prior       <= eff_prior;
      ip_protocol <= proto_next;
      frag_hi     <= frag_hi_next;
      frag_lo     <= frag_lo_next;
      tcp_words   <= tcp_words_next;
      dyn_armed   <= dyn_armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (stored) begin
        hist[2] <= hist[1];
        hist[1] <= hist[0];
        hist[0] <= item.data_byte;
      end
      dyn_end     <= dyn_end_next;
      word_ip     <= word_ip_next;
      word_l4     <= word_l4_next;
      word_l4_4   <= word_l4_4_next;
      word_l4_8   <= word_l4_8_next;
      word_l4_dyn <= word_l4_dyn_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_PACKET_BYTES))
    else $error("byte position beyond packet store limit");

  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    take && item.last_byte |=> pos == '0)
    else $error("byte position not restarted after last byte");

  a_dyn_after_doff: assert property (@(posedge clk) disable iff (rst)
    take && hit_doff |=> dyn_armed)
    else $error("payload word tracking not armed after data offset byte");

endmodule

/* hw/rtl/pfe_select.sv */
module pfe_select (
  input  pfe_pkg::pfe_summary_t summary,
  input  pfe_pkg::pfe_cfg_t     cfg,
  output pfe_pkg::pfe_out_t     result
);
  import pfe_pkg::*;

  logic             is_tcp, is_udp, tcp_room, found;
  logic [OFF_W-1:0] trans_x, len_x, base, word_end;
  logic [WORD_W-1:0] word, field, prior_sh, agg;

  assign is_tcp   = summary.ip_protocol == PROTO_TCP;
  assign is_udp   = summary.ip_protocol == PROTO_UDP;
  assign trans_x  = OFF_W'(summary.trans_offset);
  assign len_x    = OFF_W'(summary.length);
  assign tcp_room = trans_x + OFF_W'(TCP_MIN_HDR) <= len_x;

  always_comb begin
    found = 1'b0;
    base  = trans_x;
    word  = summary.word_l4;
    case (cfg.field_mode)
      MODE_IP_HEADER: begin
        found = 1'b1;
        base  = OFF_W'(summary.net_offset);
        word  = summary.word_ip;
      end
      MODE_TCP_UDP: begin
        found = summary.frag_zero && (is_tcp || is_udp);
      end
      MODE_TRANSPORT: begin
        found = summary.frag_zero;
      end
      MODE_PAYLOAD: begin
        if (summary.frag_zero && is_tcp && tcp_room) begin
          found = 1'b1;
          base  = trans_x + OFF_W'({summary.tcp_data_words, 2'b00});
          case (summary.tcp_data_words)
            4'd0:    word = summary.word_l4;
            4'd1:    word = summary.word_l4_4;
            4'd2:    word = summary.word_l4_8;
            default: word = summary.word_l4_dyn;
          endcase
        end else if (summary.frag_zero && is_udp) begin
          found = 1'b1;
          base  = trans_x + OFF_W'(UDP_HDR_BYTES);
          word  = summary.word_l4_8;
        end
      end
      MODE_PROTOCOL: begin
        found = summary.frag_zero && (summary.ip_protocol == cfg.match_protocol);
      end
      default: begin
        found = 1'b0;
      end
    endcase
  end

  assign word_end = base + OFF_W'(cfg.word_offset) + OFF_W'(WORD_BYTES);
  assign field    = (word >> cfg.shift_amount) & cfg.field_mask;
  assign prior_sh = cfg.field_length[5] ? '0 : (summary.prior << cfg.field_length[4:0]);
  assign agg      = cfg.incremental ? prior_sh + field : field;

  always_comb begin
    result.rejected  = !summary.has_net || !found || (word_end > len_x);
    result.aggregate = result.rejected ? '0 : agg;
  end

endmodule

/* hw/rtl/packet_header_field_extractor_core.sv */
// The summary register takes a packet's summary with its last byte; the result
// register then takes the result once it is free or emptying.
// Throughput: one byte per cycle while in_ready is high; one result per packet.
// The rate is set by the byte scan, which does a few offset compares per byte.
// Reset is synchronous and active high; it restores the register defaults and
// empties the summary and result stages.
module packet_header_field_extractor_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pfe_pkg::pfe_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pfe_pkg::pfe_out_t                    out_data,
  input  logic                                 cfg_write,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pfe_pkg::*;

  // The block works on a byte stream and never holds the packet itself.  For
  // every word position that any base could choose (IP header, transport
  // header, transport plus four, transport plus eight, and transport plus the
  // TCP data offset) the scan keeps the word whose last byte has gone by.  The
  // header bytes that decide the base are tracked the same way.  When the last
  // byte arrives, the packet summary is registered, the base is chosen from it
  // and the result is registered in the next stage.

  pfe_cfg_t     cfg;
  pfe_summary_t summary_next;
  pfe_summary_t summary;
  logic         sum_valid;
  pfe_out_t     result;
  logic         in_take;
  logic         sum_load;
  logic         out_load;

  // Configuration registers, written without handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_mode     <= MODE_IP_HEADER;
      cfg.match_protocol <= '0;
      cfg.word_offset    <= '0;
      cfg.shift_amount   <= '0;
      cfg.field_mask     <= '1;
      cfg.field_length   <= 6'd32;
      cfg.incremental    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIELD_MODE:     cfg.field_mode     <= pfe_mode_e'(cfg_data[2:0]);
        REG_MATCH_PROTOCOL: cfg.match_protocol <= cfg_data[7:0];
        REG_WORD_OFFSET:    cfg.word_offset    <= cfg_data[HDR_OFF_W-1:0];
        REG_SHIFT_AMOUNT:   cfg.shift_amount   <= cfg_data[4:0];
        REG_FIELD_MASK:     cfg.field_mask     <= cfg_data[WORD_W-1:0];
        REG_FIELD_LENGTH:   cfg.field_length   <= cfg_data[5:0];
        REG_INCREMENTAL:    cfg.incremental    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The result register empties when the consumer takes its transaction; the
  // summary moves on whenever the result register is free or emptying.  A new
  // byte is taken whenever the summary stage could absorb a last byte.
  assign out_load = sum_valid && (!out_valid || out_ready);
  assign in_ready = !sum_valid || out_load;
  assign in_take  = in_valid && in_ready;
  assign sum_load = in_take && in_data.last_byte;

  pfe_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .take    (in_take),
    .item    (in_data),
    .cfg     (cfg),
    .summary (summary_next)
  );

  pfe_select u_select (
    .summary (summary),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sum_valid <= sum_load || (sum_valid && !out_load);
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (sum_load) begin
      summary <= summary_next;
    end
    if (out_load) begin
      out_data <= result;
    end
  end

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rejected |-> out_data.aggregate == '0)
    else $error("bad packet transaction carries a nonzero aggregate");

  a_summary_kept: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !out_load |=> sum_valid && $stable(summary))
    else $error("packet summary lost while result stage was full");

  a_last_reaches_summary: assert property (@(posedge clk) disable iff (rst)
    sum_load |=> sum_valid)
    else $error("last byte accepted without a packet summary");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && sum_valid |-> !in_ready)
    else $error("byte accepted with both stages blocked");

endmodule

/* sim/packet_header_field_extractor_core_tb.sv */
module packet_header_field_extractor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  // Mode codes that the block does not define. They must find no base, so
  // every packet seen under them is reported as bad.
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  // Chance, in percent, that either side idles in a given cycle.
  localparam int IDLE_PCT = 23;

  // Index width of the byte copy.
  localparam int IDX_W = $clog2(MAX_PACKET_BYTES);

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic     in_valid = 1'b0;
  logic     in_ready;
  pfe_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pfe_out_t out_data;

  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  packet_header_field_extractor_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Packet bytes waiting to be offered, and the results that the packets
  // already accepted are owed, oldest first.
  pfe_in_t  byte_backlog[$];
  pfe_out_t agg_expected[$];

  // When set, neither side idles: this gives a stretch of back-to-back
  // transactions on both channels.
  logic        steady = 1'b0;
  int unsigned errors = 0;

  // Scratch buffer in which the stimulus builds one packet at a time.
  logic [7:0] pkt_buf[$];

  // Our own copy of the register file, starting from the reset defaults.
  logic [2:0]           sh_mode  = MODE_IP_HEADER;
  logic [7:0]           sh_proto = 8'h00;
  logic [HDR_OFF_W-1:0] sh_woff  = '0;
  logic [4:0]           sh_shift = 5'd0;
  logic [WORD_W-1:0]    sh_mask  = '1;
  logic [5:0]           sh_flen  = 6'd32;
  logic                 sh_incr  = 1'b0;

  // Our own copy of the byte scan: the bytes of the current packet and the
  // header details sampled with its first byte.
  logic [7:0]        seen_bytes [MAX_PACKET_BYTES];
  int unsigned       seen_count   = 0;
  logic              held_has_net = 1'b0;
  int unsigned       held_net     = 0;
  int unsigned       held_trans   = 0;
  logic [WORD_W-1:0] held_prior   = '0;

  // A header byte that lies at or beyond the packet end reads as zero.
  function automatic logic [7:0] byte_or_zero(int unsigned p, int unsigned n);
    return (p < n) ? seen_bytes[p[IDX_W-1:0]] : 8'h00;
  endfunction

  // Takes one accepted packet byte. On the last byte of a packet it works out
  // the header details, picks the base for the current mode, fetches the
  // big-endian word and files the aggregate (or the bad flag) that the block
  // must later produce.
  task automatic scan_byte(input pfe_in_t it);
    int unsigned       n;
    int unsigned       base;
    int unsigned       addr;
    logic [7:0]        proto;
    logic [7:0]        doff_byte;
    logic              frag0;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] agg;
    pfe_out_t          res;
    if (it.first_byte) begin
      seen_count   = 0;
      held_has_net = it.has_net_header;
      held_net     = 32'(it.net_offset);
      held_trans   = 32'(it.trans_offset);
      held_prior   = it.prior_aggregate;
    end
    // Bytes past the store limit are dropped; the packet then counts as
    // exactly MAX_PACKET_BYTES long.
    if (seen_count < MAX_PACKET_BYTES) begin
      seen_bytes[seen_count[IDX_W-1:0]] = it.data_byte;
      seen_count++;
    end
    if (it.last_byte) begin
      n          = seen_count;
      seen_count = 0;
      proto      = byte_or_zero(held_net + IP_PROTO_POS, n);
      // First fragment: the 13-bit fragment offset is zero, flags ignored.
      frag0      = ((byte_or_zero(held_net + IP_FRAG_HI_POS, n) & 8'h1f) |
                    byte_or_zero(held_net + IP_FRAG_LO_POS, n)) == 8'h00;
      doff_byte  = byte_or_zero(held_trans + TCP_DOFF_POS, n);
      // With no base found the base is the packet length, which always puts
      // the word beyond the end.
      base = n;
      case (sh_mode)
        MODE_IP_HEADER: base = held_net;
        MODE_TCP_UDP: begin
          if (frag0 && (proto == PROTO_TCP || proto == PROTO_UDP)) base = held_trans;
        end
        MODE_TRANSPORT: begin
          if (frag0) base = held_trans;
        end
        MODE_PAYLOAD: begin
          if (frag0) begin
            if (proto == PROTO_TCP && held_trans + TCP_MIN_HDR <= n)
              base = held_trans + 32'({doff_byte[7:4], 2'b00});
            else if (proto == PROTO_UDP)
              base = held_trans + UDP_HDR_BYTES;
          end
        end
        MODE_PROTOCOL: begin
          if (frag0 && proto == sh_proto) base = held_trans;
        end
        default: ;
      endcase
      addr = base + 32'(sh_woff);
      if (!held_has_net || addr + WORD_BYTES > n) begin
        res.aggregate = '0;
        res.rejected  = 1'b1;
      end else begin
        word = {byte_or_zero(addr, n), byte_or_zero(addr + 1, n),
                byte_or_zero(addr + 2, n), byte_or_zero(addr + 3, n)};
        agg  = (word >> sh_shift) & sh_mask;
        // A length of 32 or more clears the prior; a length of zero keeps it.
        if (sh_incr)
          agg = ((sh_flen >= 6'd32) ? 32'd0 : (held_prior << sh_flen)) + agg;
        res.aggregate = agg;
        res.rejected  = 1'b0;
      end
      agg_expected.push_back(res);
    end
  endtask

  // Byte driver. A byte, once offered, is held until its transaction
  // completes; only then may the next one be offered or the channel idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        scan_byte(in_data);
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each completed result transaction is checked against the
  // oldest outstanding expectation, field by field. The ready line stalls at
  // random outside the steady stretch.
  always @(posedge clk) begin : result_check
    pfe_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (agg_expected.size() == 0) begin
          $error("result with none expected: aggregate %h, rejected %b",
                 out_data.aggregate, out_data.rejected);
          errors++;
        end else begin
          want = agg_expected.pop_front();
          if (out_data.aggregate !== want.aggregate) begin
            $error("aggregate: expected %h, actual %h", want.aggregate, out_data.aggregate);
            errors++;
          end
          if (out_data.rejected !== want.rejected) begin
            $error("rejected: expected %b, actual %b", want.rejected, out_data.rejected);
            errors++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Writes one register and updates our copy. Bits above the register's
  // width are sometimes filled with rubbish, which the block must ignore.
  task automatic write_reg(input pfe_reg_e idx, input logic [31:0] val);
    int          w;
    logic [31:0] noisy;
    case (idx)
      REG_FIELD_MODE:     begin w = 3;  sh_mode  = val[2:0];  end
      REG_MATCH_PROTOCOL: begin w = 8;  sh_proto = val[7:0];  end
      REG_WORD_OFFSET:    begin w = 11; sh_woff  = val[10:0]; end
      REG_SHIFT_AMOUNT:   begin w = 5;  sh_shift = val[4:0];  end
      REG_FIELD_MASK:     begin w = 32; sh_mask  = val;       end
      REG_FIELD_LENGTH:   begin w = 6;  sh_flen  = val[5:0];  end
      REG_INCREMENTAL:    begin w = 1;  sh_incr  = val[0];    end
      default:            w = 32;
    endcase
    noisy = val;
    if (w < 32 && $urandom_range(1) == 1)
      noisy = val | ($urandom() << w);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= noisy;
  endtask

  task automatic set_config(input logic [2:0] mode, input logic [7:0] proto,
                            input logic [10:0] woff, input logic [4:0] shift,
                            input logic [31:0] mask, input logic [5:0] flen,
                            input logic incr);
    write_reg(REG_FIELD_MODE,     {29'd0, mode});
    write_reg(REG_MATCH_PROTOCOL, {24'd0, proto});
    write_reg(REG_WORD_OFFSET,    {21'd0, woff});
    write_reg(REG_SHIFT_AMOUNT,   {27'd0, shift});
    write_reg(REG_FIELD_MASK,     mask);
    write_reg(REG_FIELD_LENGTH,   {26'd0, flen});
    write_reg(REG_INCREMENTAL,    {31'd0, incr});
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_config();
    logic [2:0]  mode;
    int unsigned woff;
    mode = ($urandom_range(9) == 0) ? 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST))
                                    : 3'($urandom_range(MODE_PROTOCOL));
    case ($urandom_range(9))
      0:       woff = $urandom_range(19);       // unaligned offsets
      1:       woff = $urandom_range(2047);
      default: woff = WORD_BYTES * $urandom_range(4);
    endcase
    set_config(mode,
               $urandom_range(1) ? ($urandom_range(1) ? PROTO_TCP : PROTO_UDP)
                                 : 8'($urandom_range(255)),
               11'(woff), 5'($urandom_range(31)),
               ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom(),
               ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32, 1)),
               1'($urandom_range(1)));
  endtask

  // Turns the scratch buffer into byte transactions. The header details ride
  // with the first byte; on every other byte they carry rubbish, which the
  // block must ignore. With lead clear the packet has no first-byte mark and
  // reuses what was sampled last; restart_pct sprinkles stray first-byte
  // marks into the middle of the packet.
  task automatic queue_packet(input logic has_net, input int unsigned net,
                              input int unsigned trans, input logic [31:0] prior,
                              input logic lead, input int restart_pct);
    pfe_in_t it;
    foreach (pkt_buf[i]) begin
      it.data_byte  = pkt_buf[i];
      it.first_byte = (i == 0) ? lead : ($urandom_range(99) < restart_pct);
      it.last_byte  = (i == pkt_buf.size() - 1);
      if (i == 0) begin
        it.has_net_header  = has_net;
        it.net_offset      = HDR_OFF_W'(net);
        it.trans_offset    = HDR_OFF_W'(trans);
        it.prior_aggregate = prior;
      end else begin
        it.has_net_header  = 1'($urandom_range(1));
        it.net_offset      = HDR_OFF_W'($urandom_range(2047));
        it.trans_offset    = HDR_OFF_W'($urandom_range(2047));
        it.prior_aggregate = $urandom();
      end
      byte_backlog.push_back(it);
    end
  endtask

  // A plausible IP packet: random content with the protocol, fragment field
  // and TCP data offset placed where the block looks for them, long enough
  // for most word fetches to land inside. Now and then it is cut short.
  task automatic queue_ip_packet();
    int unsigned net, trans, hdr, len, doff, pick;
    logic [7:0]  proto;
    logic [12:0] frag;
    logic [2:0]  flags;
    logic [3:0]  nib;
    net   = $urandom_range(16);
    trans = net + (($urandom_range(1) == 1) ? 20 : WORD_BYTES * $urandom_range(15, 5));
    pick  = $urandom_range(9);
    if (pick < 4)      proto = PROTO_TCP;
    else if (pick < 7) proto = PROTO_UDP;
    else if (pick < 9) proto = sh_proto;
    else               proto = 8'($urandom_range(255));
    doff = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
    if (proto == PROTO_TCP)
      hdr = (WORD_BYTES * doff > TCP_MIN_HDR) ? WORD_BYTES * doff : TCP_MIN_HDR;
    else
      hdr = UDP_HDR_BYTES;
    len = trans + hdr + $urandom_range(24);
    if ($urandom_range(9) == 0)
      len = $urandom_range(len, 1);
    frag  = ($urandom_range(7) == 0) ? 13'($urandom_range(8191, 1)) : 13'd0;
    flags = 3'($urandom_range(7));
    nib   = 4'($urandom_range(15));
    pkt_buf.delete();
    repeat (len) pkt_buf.push_back(8'($urandom_range(255)));
    if (net + IP_FRAG_HI_POS < len) pkt_buf[net + IP_FRAG_HI_POS] = {flags, frag[12:8]};
    if (net + IP_FRAG_LO_POS < len) pkt_buf[net + IP_FRAG_LO_POS] = frag[7:0];
    if (net + IP_PROTO_POS < len)   pkt_buf[net + IP_PROTO_POS]   = proto;
    if (proto == PROTO_TCP && trans + TCP_DOFF_POS < len)
      pkt_buf[trans + TCP_DOFF_POS] = {doff[3:0], nib};
    queue_packet($urandom_range(19) != 0, net, trans, $urandom(), $urandom_range(19) != 0, 0);
  endtask

  // Short rubbish packets with random offsets, occasionally missing the
  // first-byte mark or carrying a stray one.
  task automatic queue_noise_packet();
    int unsigned len;
    len = $urandom_range(48, 1);
    pkt_buf.delete();
    repeat (len) pkt_buf.push_back(8'($urandom_range(255)));
    queue_packet(1'($urandom_range(1)), $urandom_range(63), $urandom_range(63), $urandom(),
                 $urandom_range(3) != 0, 3);
  endtask

  // Holds the sender back until every outstanding result has arrived, then
  // lets the result pipeline settle.
  task automatic wait_quiet();
    while (byte_backlog.size() != 0 || in_valid || agg_expected.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed packets under the reset configuration. The very first byte
    // carries no first-byte mark, so it uses the cleared header state and has
    // no network header.
    pkt_buf = '{8'hff};
    queue_packet(1'b1, 0, 0, 32'hffff_ffff, 1'b0, 0);
    // A clean four-byte word at the IP header.
    pkt_buf = '{8'hff, 8'h00, 8'hff, 8'h00};
    queue_packet(1'b1, 0, 0, 32'hffff_ffff, 1'b1, 0);
    // No first-byte mark after a last byte: the previous sample is reused.
    pkt_buf = '{8'h00, 8'hff, 8'h00, 8'hff};
    queue_packet(1'b0, 2047, 2047, 32'h0000_0000, 1'b0, 0);
    // No network header.
    pkt_buf = '{8'h12, 8'h34, 8'h56, 8'h78};
    queue_packet(1'b0, 0, 0, 32'h0000_0000, 1'b1, 0);
    // Offsets at their largest, far beyond the packet end.
    pkt_buf = '{8'h00, 8'hff, 8'h00, 8'hff};
    queue_packet(1'b1, 2047, 2047, 32'hffff_ffff, 1'b1, 0);
    // Packet one byte too short for the word.
    pkt_buf = '{8'ha5, 8'h5a, 8'hc3};
    queue_packet(1'b1, 0, 0, 32'h0000_0000, 1'b1, 0);
    wait_quiet();

    // An undefined mode finds no base, so even a clean packet is bad.
    set_config(MODE_UNUSED_LAST, 8'h00, 11'd0, 5'd0, 32'hffff_ffff, 6'd32, 1'b0);
    pkt_buf = '{8'h01, 8'h02, 8'h03, 8'h04};
    queue_packet(1'b1, 0, 0, 32'h0000_0000, 1'b1, 0);
    wait_quiet();

    // Random phases, each under its own configuration, with a full pause
    // between them so that registers only change while the block is idle.
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        // Lowest settings: a zero mask and a zero length, so the prior
        // comes through untouched.
        0: set_config(MODE_IP_HEADER, 8'h00, 11'd0, 5'd0, 32'h0000_0000, 6'd0, 1'b1);
        // Highest settings, with the prior shifted right out.
        1: set_config(MODE_IP_HEADER, 8'hff, 11'd2044, 5'd31, 32'hffff_ffff, 6'd63, 1'b1);
        2: set_config(MODE_TCP_UDP, PROTO_TCP, 11'd0, 5'($urandom_range(31)), $urandom(),
                      6'd32, 1'b1);
        3: set_config(MODE_TRANSPORT, 8'h00, 11'd4, 5'd0, 32'hffff_ffff, 6'd16, 1'b0);
        4: set_config(MODE_PAYLOAD, 8'h00, 11'd0, 5'($urandom_range(31)), 32'hffff_ffff,
                      6'($urandom_range(32, 1)), 1'b1);
        5: set_config(MODE_PROTOCOL, PROTO_UDP, 11'd0, 5'd0, 32'hffff_ffff, 6'd8, 1'b1);
        default: random_config();
      endcase
      steady = (phase == 8 || phase == 9);
      sent   = 0;
      while (sent < 100) begin
        if ($urandom_range(99) < 82)
          queue_ip_packet();
        else
          queue_noise_packet();
        sent += pkt_buf.size();
      end
      wait_quiet();
    end
    steady = 1'b0;

    if (errors == 0)
      $display("packet_header_field_extractor_core_tb OK");
    else
      $display("packet_header_field_extractor_core_tb NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with both sides stalling.
  initial begin
    #3_000_000;
    $display("packet_header_field_extractor_core_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_scan.sv
hw/rtl/pfe_select.sv
hw/rtl/packet_header_field_extractor_core.sv
sim/packet_header_field_extractor_core_tb.sv
